// File: rtl/core/keyframe_path_stepper_assert.svh
// ----------------------------------------------------------------------------
// Keyframe path stepper assertion macros
// Shorthand for clocked implication checks with a synchronous reset.
// ----------------------------------------------------------------------------
`ifndef KEYFRAME_PATH_STEPPER_ASSERT_SVH
`define KEYFRAME_PATH_STEPPER_ASSERT_SVH

// same-cycle implication
`define KPS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define KPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/kps_pkg.sv
// ----------------------------------------------------------------------------
// kps_pkg
// Shared types and fixed field widths for the keyframe path stepper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package kps_pkg;

   localparam int POS_BITS   = 16;
   localparam int DUR_BITS   = 16;
   localparam int IMAGE_BITS = 8;
   localparam int INDEX_BITS = 6;
   localparam int COUNT_BITS = 7;

   localparam logic CMD_TICK  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_RD_DUR = 9'b000000010,
      ST_CHECK  = 9'b000000100,
      ST_LD_RD0 = 9'b000001000,
      ST_LD_RD1 = 9'b000010000,
      ST_LD_DIFF = 9'b000100000,
      ST_DIV    = 9'b001000000,
      ST_IMG_RD = 9'b010000000,
      ST_IMG    = 9'b100000000
   } kps_state_type;

endpackage

`default_nettype wire

// File: rtl/core/keyframe_path_stepper.sv
// ----------------------------------------------------------------------------
// keyframe_path_stepper
// Sprite motion sequencer stepping linearly between stored keyframes.
// ----------------------------------------------------------------------------
// Usage:
//  - A command word is taken when start is high and busy is low. A write
//    word stores one keyframe and stops playback; a tick word steps a frame.
//  - Every command gives exactly one response word, shown for one cycle with
//    rsp_valid high. The receiver cannot stall; the response is always taken.
//  - Write: the response comes the cycle after accept, busy stays low.
//  - Tick inside a segment: RD_DUR reads the entry, CHECK registers the response.
//  - Tick that enters a new segment: one shared restoring divider produces
//    the x step and then the y step, one quotient bit per cycle. The first
//    tick after reset or a write loads segment 0 first.
//    busy is high during the whole tick.
//  - The keyframe table is a single-port-read memory, one read per cycle.
//  - csr_write_data sets the keyframe count; write it only while idle.
//  - Synchronous reset: idle, not playing, position and steps zero, keyframe
//    count one. Table contents are not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module keyframe_path_stepper
   import kps_pkg::*;
#(
   parameter int KEYFRAMES  = 64,
   parameter int COORD_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic                         req_command,
   input  logic [INDEX_BITS-1:0]        req_entry_index,
   input  logic signed [POS_BITS-1:0]   req_key_x,
   input  logic signed [POS_BITS-1:0]   req_key_y,
   input  logic [DUR_BITS-1:0]          req_key_duration,
   input  logic [IMAGE_BITS-1:0]        req_key_image,
   output logic                         rsp_valid,
   output logic signed [POS_BITS-1:0]   rsp_pos_x,
   output logic signed [POS_BITS-1:0]   rsp_pos_y,
   output logic [IMAGE_BITS-1:0]        rsp_image_number,
   output logic                         rsp_cycle_done,
   input  logic                         csr_write_enable,
   input  logic [COUNT_BITS-1:0]        csr_write_data
);

   localparam int SEG_W  = $clog2(KEYFRAMES);
   localparam int CLG_K  = $clog2(KEYFRAMES + 1);
   localparam int ACT_W  = (CLG_K > COUNT_BITS) ? CLG_K : COUNT_BITS;
   localparam int CMP_W  = ACT_W + 1;
   localparam int EXT_W  = ((SEG_W > INDEX_BITS) ? SEG_W : INDEX_BITS) + 1;
   localparam int QW     = COORD_BITS + 1;
   localparam int CNT_W  = $clog2(QW);
   localparam int WORD_W = 2 * COORD_BITS + DUR_BITS + IMAGE_BITS;

   // keyframe table
   logic [WORD_W-1:0]     kf_mem_ff [KEYFRAMES];
   logic [WORD_W-1:0]     rd_word_ff;
   logic [SEG_W-1:0]      rd_addr;
   logic                  mem_we;
   logic [SEG_W-1:0]      wr_addr;
   logic [WORD_W-1:0]     wr_word;

   logic [COORD_BITS-1:0] rd_x, rd_y;
   logic [DUR_BITS-1:0]   rd_dur;
   logic [IMAGE_BITS-1:0] rd_img;

   kps_state_type         state_ff, state_in;
   logic                  playing_ff, playing_in;
   logic                  init_ff, init_in;
   logic                  done_ff, done_in;
   logic [SEG_W-1:0]      segment_ff, segment_in;
   logic [DUR_BITS-1:0]   frame_ff, frame_in;
   logic [COORD_BITS-1:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic [COORD_BITS-1:0] step_x_ff, step_x_in, step_y_ff, step_y_in;
   logic [COUNT_BITS-1:0] kf_count_ff, kf_count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_done_ff, rsp_done_in;
   logic [IMAGE_BITS-1:0] rsp_image_ff, rsp_image_in;

   // divider and segment load datapath
   logic [DUR_BITS-1:0]   dur_ff, dur_in;
   logic [QW-1:0]         diff_y_ff, diff_y_in;
   logic [QW-1:0]         num_ff, num_in;
   logic [DUR_BITS:0]     rem_ff, rem_in;
   logic                  neg_ff, neg_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  sel_y_ff, sel_y_in;

   logic                  accept;
   logic [CMP_W-1:0]      count_ext, active, seg_plus;
   logic                  last_seg;
   logic [EXT_W-1:0]      idx_ext;
   logic                  write_ok;
   logic [DUR_BITS-1:0]   frame_next;
   logic [QW-1:0]         diff_x, diff_y;
   logic [QW-1:0]         op, op_mag;
   logic                  op_neg;
   logic [DUR_BITS:0]     rem_sh, rem_next;
   logic                  ge;
   logic [QW-1:0]         num_next, quot;
   logic                  last_iter;
   kps_state_type         after_load;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   assign rd_x   = rd_word_ff[WORD_W-1 -: COORD_BITS];
   assign rd_y   = rd_word_ff[WORD_W-1-COORD_BITS -: COORD_BITS];
   assign rd_dur = rd_word_ff[IMAGE_BITS +: DUR_BITS];
   assign rd_img = rd_word_ff[IMAGE_BITS-1:0];

   // clamp keyframe count into 1..KEYFRAMES
   assign count_ext = CMP_W'(kf_count_ff);
   assign active    = (count_ext == '0) ? CMP_W'(1) :
                      (count_ext > CMP_W'(KEYFRAMES)) ? CMP_W'(KEYFRAMES) : count_ext;
   assign seg_plus  = CMP_W'(segment_ff) + CMP_W'(1);
   assign last_seg  = (seg_plus >= active);

   assign idx_ext  = EXT_W'(req_entry_index);
   assign write_ok = (idx_ext < EXT_W'(KEYFRAMES));
   assign wr_addr  = idx_ext[SEG_W-1:0];
   assign wr_word  = {COORD_BITS'(req_key_x), COORD_BITS'(req_key_y),
                      req_key_duration, req_key_image};

   // last segment holds keyframe 0; otherwise read this entry, then the next
   assign rd_addr = (state_ff == ST_LD_RD0 && last_seg) ? '0 :
                    (state_ff == ST_LD_RD1) ? seg_plus[SEG_W-1:0] : segment_ff;

   assign frame_next = frame_ff + DUR_BITS'(1);

   assign diff_x = {rd_x[COORD_BITS-1], rd_x} - {cur_x_ff[COORD_BITS-1], cur_x_ff};
   assign diff_y = {rd_y[COORD_BITS-1], rd_y} - {cur_y_ff[COORD_BITS-1], cur_y_ff};

   // divider operand: x straight from the table, y from its holding register
   assign op     = (state_ff == ST_LD_DIFF) ? diff_x : diff_y_ff;
   assign op_neg = op[QW-1];
   assign op_mag = op_neg ? (~op + QW'(1)) : op;

   assign rem_sh    = {rem_ff[DUR_BITS-1:0], num_ff[QW-1]};
   assign ge        = (rem_sh >= {1'b0, dur_ff});
   assign rem_next  = ge ? (rem_sh - {1'b0, dur_ff}) : rem_sh;
   assign num_next  = {num_ff[QW-2:0], ge};
   assign quot      = neg_ff ? (~num_next + QW'(1)) : num_next;
   assign last_iter = (cnt_ff == CNT_W'(QW - 1));

   assign after_load = init_ff ? ST_RD_DUR : ST_IMG_RD;

   always_comb begin
      state_in     = state_ff;
      playing_in   = playing_ff;
      init_in      = init_ff;
      done_in      = done_ff;
      segment_in   = segment_ff;
      frame_in     = frame_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      step_x_in    = step_x_ff;
      step_y_in    = step_y_ff;
      dur_in       = dur_ff;
      diff_y_in    = diff_y_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      neg_in       = neg_ff;
      cnt_in       = cnt_ff;
      sel_y_in     = sel_y_ff;
      rsp_valid_in = 1'b0;
      rsp_done_in  = 1'b0;
      rsp_image_in = rsp_image_ff;
      mem_we       = 1'b0;
      kf_count_in  = csr_write_enable ? csr_write_data : kf_count_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_command == CMD_WRITE) begin
                  mem_we       = write_ok;
                  playing_in   = 1'b0;
                  rsp_valid_in = 1'b1;
                  rsp_image_in = '0;
               end else begin
                  done_in = 1'b0;
                  if (!playing_ff) begin
                     segment_in = '0;
                     frame_in   = '0;
                     playing_in = 1'b1;
                     init_in    = 1'b1;
                     state_in   = ST_LD_RD0;
                  end else begin
                     state_in = ST_RD_DUR;
                  end
               end
            end
         end
         ST_RD_DUR: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            cur_x_in = cur_x_ff + step_x_ff;
            cur_y_in = cur_y_ff + step_y_ff;
            if (frame_next >= rd_dur) begin
               frame_in = '0;
               if (last_seg) begin
                  segment_in = '0;
                  done_in    = 1'b1;
               end else begin
                  segment_in = seg_plus[SEG_W-1:0];
               end
               state_in = ST_LD_RD0;
            end else begin
               // same segment: image is already in the read register
               frame_in     = frame_next;
               rsp_valid_in = 1'b1;
               rsp_image_in = rd_img;
               state_in     = ST_IDLE;
            end
         end
         ST_LD_RD0: begin
            state_in = ST_LD_RD1;
         end
         ST_LD_RD1: begin
            cur_x_in = rd_x;
            cur_y_in = rd_y;
            if (last_seg) begin
               step_x_in = '0;
               step_y_in = '0;
               init_in   = 1'b0;
               state_in  = after_load;
            end else begin
               dur_in   = rd_dur;
               state_in = ST_LD_DIFF;
            end
         end
         ST_LD_DIFF: begin
            diff_y_in = diff_y;
            if (dur_ff == '0) begin
               step_x_in = diff_x[COORD_BITS-1:0];
               step_y_in = diff_y[COORD_BITS-1:0];
               init_in   = 1'b0;
               state_in  = after_load;
            end else begin
               num_in   = op_mag;
               neg_in   = op_neg;
               rem_in   = '0;
               cnt_in   = '0;
               sel_y_in = 1'b0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            num_in = num_next;
            rem_in = rem_next;
            cnt_in = cnt_ff + CNT_W'(1);
            if (last_iter) begin
               if (!sel_y_ff) begin
                  // x done, restart the divider on y
                  step_x_in = quot[COORD_BITS-1:0];
                  num_in    = op_mag;
                  neg_in    = op_neg;
                  rem_in    = '0;
                  cnt_in    = '0;
                  sel_y_in  = 1'b1;
               end else begin
                  step_y_in = quot[COORD_BITS-1:0];
                  init_in   = 1'b0;
                  state_in  = after_load;
               end
            end
         end
         ST_IMG_RD: begin
            state_in = ST_IMG;
         end
         ST_IMG: begin
            rsp_valid_in = 1'b1;
            rsp_image_in = rd_img;
            rsp_done_in  = done_ff;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         playing_ff   <= 1'b0;
         init_ff      <= 1'b0;
         done_ff      <= 1'b0;
         segment_ff   <= '0;
         frame_ff     <= '0;
         cur_x_ff     <= '0;
         cur_y_ff     <= '0;
         step_x_ff    <= '0;
         step_y_ff    <= '0;
         kf_count_ff  <= COUNT_BITS'(1);
         rsp_valid_ff <= 1'b0;
         rsp_done_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         playing_ff   <= playing_in;
         init_ff      <= init_in;
         done_ff      <= done_in;
         segment_ff   <= segment_in;
         frame_ff     <= frame_in;
         cur_x_ff     <= cur_x_in;
         cur_y_ff     <= cur_y_in;
         step_x_ff    <= step_x_in;
         step_y_ff    <= step_y_in;
         kf_count_ff  <= kf_count_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_done_ff  <= rsp_done_in;
      end
   end

   always_ff @(posedge clock) begin
      dur_ff       <= dur_in;
      diff_y_ff    <= diff_y_in;
      num_ff       <= num_in;
      rem_ff       <= rem_in;
      neg_ff       <= neg_in;
      cnt_ff       <= cnt_in;
      sel_y_ff     <= sel_y_in;
      rsp_image_ff <= rsp_image_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we && !reset) begin
         kf_mem_ff[wr_addr] <= wr_word;
      end
      rd_word_ff <= kf_mem_ff[rd_addr];
   end

   // position is final by the response cycle and holds until the next tick
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pos_x        = POS_BITS'(cur_x_ff);
   assign rsp_pos_y        = POS_BITS'(cur_y_ff);
   assign rsp_image_number = rsp_image_ff;
   assign rsp_cycle_done   = rsp_done_ff;

endmodule

`default_nettype wire

// File: rtl/core/kps_checker.sv
// ----------------------------------------------------------------------------
// kps_checker
// Port-level checks on the keyframe path stepper command and response words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "keyframe_path_stepper_assert.svh"

module kps_checker
   import kps_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic                  busy,
   input  wire logic                  req_command,
   input  wire logic                  rsp_valid,
   input  wire logic [IMAGE_BITS-1:0] rsp_image_number,
   input  wire logic                  rsp_cycle_done
);

   logic accept_word;
   logic write_word;
   logic write_rsp_ok;

   assign accept_word  = start && !busy;
   assign write_word   = accept_word && !reset && (req_command == CMD_WRITE);
   assign write_rsp_ok = rsp_valid && (rsp_image_number == '0) && !rsp_cycle_done;

   `KPS_ASSERT_IMPL(a_rsp_when_idle, clock, reset, rsp_valid, !busy, "response word while busy")

   `KPS_ASSERT_IMPL(a_done_with_rsp, clock, reset, rsp_cycle_done, rsp_valid, "stray cycle_done")

   `KPS_ASSERT_NEXT(a_accept_progress, clock, reset, accept_word, rsp_valid || busy, "word dropped")

   `KPS_ASSERT_IMPL(a_write_rsp, clock, reset, $past(write_word), write_rsp_ok, "bad write response")

endmodule

bind keyframe_path_stepper kps_checker u_kps_checker (.*);

`default_nettype wire
